// File: hw/rtl/tsc_pkg.sv
package tsc_pkg;

   localparam int TABLE_SEGMENTS = 256;
   localparam int SEG_BITS       = $clog2(TABLE_SEGMENTS);
   localparam int IDX_W          = SEG_BITS + 1;
   localparam int U_W            = 32;
   localparam int FRAC_W         = U_W - 1 - SEG_BITS;
   localparam int TAB_W          = 16;
   localparam int SAMPLE_W       = 16;
   localparam int OUT_W          = 17;
   localparam int GAIN_W         = 17;

   localparam logic [GAIN_W-1:0] UNITY       = GAIN_W'(65536);
   localparam logic [GAIN_W-1:0] DRIVE_RESET = GAIN_W'(65536);
   localparam logic [GAIN_W-1:0] WET_RESET   = GAIN_W'(32768);

   localparam logic [63:0] Q48_ONE = 64'd1 << 48;
   localparam logic [63:0] PI_Q30  = 64'd3373259426;

   typedef enum logic [0:0] {
      CSR_DRIVE_GAIN = 1'b0,
      CSR_WET_MIX    = 1'b1
   } csr_index_type;

   // shift and subtract quotient, used only while building the table
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo;
      logic [63:0] rem;
      quo = '0;
      rem = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[62:0], num[i]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // round(32768 * (pi/2) * tanh(k / TABLE_SEGMENTS)) from the exp series
   function automatic logic [TAB_W-1:0] shaper_point(input int k);
      logic [63:0] e;
      logic [63:0] term;
      logic [63:0] num;
      logic [63:0] den;
      logic [63:0] rem;
      logic [63:0] quo;
      logic [63:0] prod;
      int          n;
      e    = Q48_ONE;
      term = Q48_ONE;
      n    = 1;
      while (n < 80 && term != 64'd0) begin
         term = udiv64(term * 64'(2 * k), 64'(TABLE_SEGMENTS * n));
         e    = e + term;
         n    = n + 1;
      end
      num = e - Q48_ONE;
      den = e + Q48_ONE;
      rem = num;
      quo = '0;
      for (int i = 0; i < 32; i++) begin
         rem = rem << 1;
         quo = quo << 1;
         if (rem >= den) begin
            rem    = rem - den;
            quo[0] = 1'b1;
         end
      end
      prod = quo * PI_Q30;
      prod = (prod + (64'd1 << 47)) >> 48;
      return prod[TAB_W-1:0];
   endfunction

endpackage

// File: hw/rtl/tanh_soft_clip_mixer.sv
// channel | direction | handshake           | payload
// req     | in        | req_valid/req_stall | req_sample_in  (signed Q1.15)
// rsp     | out       | rsp_valid/rsp_stall | rsp_sample_out (signed Q2.15)
// csr     | in        | csr_valid/csr_ready | csr_index, csr_data (Q1.16, clamped)
//
// one sample per cycle while rsp_stall lets the pipeline move; the pipeline stages
// are drive multiply, table lookup, interpolation multiply, mix multiplies and final add
// each stage holds its transaction under stall and refills as soon as it empties,
// so bubbles are squeezed out while the output waits
// synchronous reset clears the valid bits and sets the gains to their defaults
module tanh_soft_clip_mixer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [tsc_pkg::SAMPLE_W-1:0]  req_sample_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [tsc_pkg::OUT_W-1:0]     rsp_sample_out,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  tsc_pkg::csr_index_type               csr_index,
   input  logic [tsc_pkg::GAIN_W-1:0]           csr_data
);
   import tsc_pkg::*;

   localparam int STAGES = 5;
   localparam int PROD_W = TAB_W + FRAC_W;
   localparam int MIX_W  = 35;
   localparam logic [PROD_W:0] INTERP_HALF = (PROD_W + 1)'(1) << (FRAC_W - 1);
   localparam logic signed [MIX_W-1:0] MIX_HALF = MIX_W'(32768);

   // configuration
   logic [GAIN_W-1:0] drive_gain_ff;
   logic [GAIN_W-1:0] wet_mix_ff;
   logic [GAIN_W-1:0] csr_clamped;

   // pipeline control
   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] load;
   logic [STAGES-1:0] prev_valid;

   // stage 0: drive product
   logic [SAMPLE_W-1:0]        mag;
   logic [U_W:0]               u_full;
   logic [U_W-1:0]             s0_u_ff;
   logic                       s0_neg_ff;
   logic signed [SAMPLE_W-1:0] s0_x_ff;

   // stage 1: table lookup
   logic [IDX_W-1:0]           lut_idx;
   logic [TAB_W-1:0]           lut_lo;
   logic [TAB_W-1:0]           lut_diff;
   logic [TAB_W-1:0]           s1_lo_ff;
   logic [TAB_W-1:0]           s1_d_ff;
   logic [FRAC_W-1:0]          s1_f_ff;
   logic                       s1_neg_ff;
   logic signed [SAMPLE_W-1:0] s1_x_ff;

   // stage 2: interpolation
   logic [PROD_W-1:0]          interp_prod;
   logic [PROD_W:0]            interp_sum;
   logic [TAB_W-1:0]           shaped_in;
   logic [TAB_W-1:0]           s2_shaped_ff;
   logic                       s2_neg_ff;
   logic signed [SAMPLE_W-1:0] s2_x_ff;

   // stage 3: mix products
   logic signed [TAB_W:0]      shaped_s;
   logic signed [TAB_W:0]      wet_y;
   logic [GAIN_W-1:0]          dry_gain;
   logic signed [MIX_W-1:0]    dry_in;
   logic signed [MIX_W-1:0]    wet_in;
   logic signed [MIX_W-1:0]    s3_dry_ff;
   logic signed [MIX_W-1:0]    s3_wet_ff;

   // stage 4: sum and round
   logic signed [MIX_W-1:0]    mix_sum;
   logic signed [OUT_W-1:0]    out_ff;

   assign csr_ready   = 1'b1;
   assign csr_clamped = (csr_data > UNITY) ? UNITY : csr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_gain_ff <= DRIVE_RESET;
         wet_mix_ff    <= WET_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DRIVE_GAIN: drive_gain_ff <= csr_clamped;
            CSR_WET_MIX:    wet_mix_ff    <= csr_clamped;
            default: ;
         endcase
      end
   end

   // a stage loads when it is empty or its contents move on
   always_comb begin
      load[STAGES-1] = !valid_ff[STAGES-1] || !rsp_stall;
      for (int k = STAGES - 2; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
      prev_valid = {valid_ff[STAGES-2:0], req_valid};
      for (int k = 0; k < STAGES; k++) begin
         valid_in[k] = load[k] ? prev_valid[k] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall      = !load[0];
   assign rsp_valid      = valid_ff[STAGES-1];
   assign rsp_sample_out = out_ff;

   // stage 0
   assign mag    = req_sample_in[SAMPLE_W-1] ? SAMPLE_W'(-req_sample_in)
                                             : SAMPLE_W'(req_sample_in);
   assign u_full = mag * drive_gain_ff;

   always_ff @(posedge clock) begin
      if (load[0] && prev_valid[0]) begin
         s0_u_ff   <= u_full[U_W-1:0];
         s0_neg_ff <= req_sample_in[SAMPLE_W-1];
         s0_x_ff   <= req_sample_in;
      end
   end

   // stage 1
   assign lut_idx = s0_u_ff[U_W-1 -: IDX_W];

   tsc_lut u_lut (
      .idx  (lut_idx),
      .lo   (lut_lo),
      .diff (lut_diff)
   );

   always_ff @(posedge clock) begin
      if (load[1] && prev_valid[1]) begin
         s1_lo_ff  <= lut_lo;
         s1_d_ff   <= lut_diff;
         s1_f_ff   <= s0_u_ff[FRAC_W-1:0];
         s1_neg_ff <= s0_neg_ff;
         s1_x_ff   <= s0_x_ff;
      end
   end

   // stage 2, nearest rounding with ties up
   assign interp_prod = s1_d_ff * s1_f_ff;
   assign interp_sum  = {1'b0, interp_prod} + INTERP_HALF;
   assign shaped_in   = TAB_W'(s1_lo_ff + interp_sum[FRAC_W +: TAB_W]);

   always_ff @(posedge clock) begin
      if (load[2] && prev_valid[2]) begin
         s2_shaped_ff <= shaped_in;
         s2_neg_ff    <= s1_neg_ff;
         s2_x_ff      <= s1_x_ff;
      end
   end

   // stage 3, odd symmetry and the two mix products
   assign shaped_s = $signed({1'b0, s2_shaped_ff});
   assign wet_y    = s2_neg_ff ? -shaped_s : shaped_s;
   assign dry_gain = GAIN_W'(UNITY - wet_mix_ff);
   assign dry_in   = $signed({1'b0, dry_gain}) * s2_x_ff;
   assign wet_in   = $signed({1'b0, wet_mix_ff}) * wet_y;

   always_ff @(posedge clock) begin
      if (load[3] && prev_valid[3]) begin
         s3_dry_ff <= dry_in;
         s3_wet_ff <= wet_in;
      end
   end

   // stage 4, floor of (sum + half) / 65536
   assign mix_sum = s3_dry_ff + s3_wet_ff + MIX_HALF;

   always_ff @(posedge clock) begin
      if (load[4] && prev_valid[4]) begin
         out_ff <= mix_sum[16 +: OUT_W];
      end
   end

endmodule

// File: hw/rtl/tsc_lut.sv
module tsc_lut (
   input  logic [tsc_pkg::IDX_W-1:0] idx,
   output logic [tsc_pkg::TAB_W-1:0] lo,
   output logic [tsc_pkg::TAB_W-1:0] diff
);
   import tsc_pkg::*;

   logic [TAB_W-1:0] tab [0:TABLE_SEGMENTS];
   logic [TAB_W-1:0] hi;
   logic [IDX_W-1:0] idx_hi;

   for (genvar g = 0; g <= TABLE_SEGMENTS; g++) begin : g_tab
      localparam logic [TAB_W-1:0] POINT = shaper_point(g);
      assign tab[g] = POINT;
   end

   always_comb begin
      idx_hi = (idx >= IDX_W'(TABLE_SEGMENTS)) ? IDX_W'(TABLE_SEGMENTS) : IDX_W'(idx + 1'b1);
      hi     = tab[idx_hi];
      if (idx >= IDX_W'(TABLE_SEGMENTS)) begin
         // end of the curve, no interpolation
         lo   = tab[TABLE_SEGMENTS];
         diff = '0;
      end else begin
         lo   = tab[idx];
         diff = (hi >= lo) ? TAB_W'(hi - lo) : '0;
      end
   end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import tsc_pkg::*;

   localparam int PIPE_LATENCY = 5;
   localparam int SETTLE_CYCLES = 4 * PIPE_LATENCY;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_ITEMS = 100;
   localparam int FILL_ITEMS = 64;
   localparam int HOLD_CYCLES = 200;
   localparam int TAIL_ITEMS = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [SAMPLE_W-1:0] req_sample_in = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [OUT_W-1:0] rsp_sample_out;
   logic csr_valid = 1'b0;
   logic csr_ready;
   csr_index_type csr_index = CSR_DRIVE_GAIN;
   logic [GAIN_W-1:0] csr_data = '0;

   // predictor state
   logic [TAB_W-1:0] tanh_lut [0:TABLE_SEGMENTS];
   logic [GAIN_W-1:0] drive_gain_cfg = DRIVE_RESET;
   logic [GAIN_W-1:0] wet_mix_cfg = WET_RESET;
   logic signed [OUT_W-1:0] mix_expect_q [$];
   logic signed [OUT_W-1:0] expected_out;

   int error_count = 0;
   int cycle_count = 0;
   logic idling_on = 1'b0;
   logic hold_toggle = 1'b0;
   logic hold_seen = 1'b0;
   int hold_left = 0;
   int stall_left = 0;

   tanh_soft_clip_mixer DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // (pi/2)*tanh(k/segments) in Q15 via exp series and long division
   function automatic logic [TAB_W-1:0] tanh_lut_point(input longint unsigned k);
      longint unsigned expo;
      longint unsigned term;
      longint unsigned numer;
      longint unsigned denom;
      longint unsigned rem;
      longint unsigned quot;
      longint unsigned prod;
      longint unsigned n;
      expo = Q48_ONE;
      term = Q48_ONE;
      quot = 0;
      for (n = 1; n < 80 && term != 0; n++) begin
         term = (term * (2 * k)) / (longint'(TABLE_SEGMENTS) * n);
         expo = expo + term;
      end
      numer = expo - Q48_ONE;
      denom = expo + Q48_ONE;
      rem = numer;
      for (int i = 0; i < 32; i++) begin
         rem = rem << 1;
         quot = quot << 1;
         if (rem >= denom) begin
            rem = rem - denom;
            quot = quot | 1;
         end
      end
      prod = quot * PI_Q30;
      prod = (prod + (64'd1 << 47)) >> 48;
      return prod[TAB_W-1:0];
   endfunction

   function automatic logic [GAIN_W-1:0] clamp_gain(input logic [GAIN_W-1:0] v);
      return (v > UNITY) ? UNITY : v;
   endfunction

   function automatic logic signed [OUT_W-1:0] shape_and_mix(
         input logic signed [SAMPLE_W-1:0] x);
      longint xs;
      longint mag;
      longint p;
      longint seg;
      longint frac;
      longint lo;
      longint hi;
      longint delta;
      longint shaped;
      longint wet;
      longint acc;
      longint rounded;
      xs = longint'(x);
      mag = (xs < 0) ? -xs : xs;
      p = mag * longint'(drive_gain_cfg) * TABLE_SEGMENTS;
      seg = p >>> 31;
      frac = p & 64'h7FFF_FFFF;
      if (seg >= TABLE_SEGMENTS) begin
         shaped = longint'(tanh_lut[TABLE_SEGMENTS]);
      end else begin
         lo = longint'(tanh_lut[seg]);
         hi = longint'(tanh_lut[seg + 1]);
         delta = (hi >= lo) ? hi - lo : 0;
         shaped = lo + ((delta * frac + (64'sd1 <<< 30)) >>> 31);
      end
      if (xs < 0) begin
         shaped = -shaped;
      end
      wet = longint'(wet_mix_cfg);
      acc = (longint'(UNITY) - wet) * xs + wet * shaped;
      // floor division, ties go up
      rounded = (acc + 32768) >>> 16;
      return rounded[OUT_W-1:0];
   endfunction

   // receiver side: long hold on request, else random stall bursts while idling_on is set
   always @(posedge clock) begin
      if (hold_toggle != hold_seen) begin
         hold_seen <= hold_toggle;
         hold_left <= HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 7);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (mix_expect_q.size() == 0) begin
            $error("unexpected rsp transaction: sample_out %0d", rsp_sample_out);
            error_count++;
         end else begin
            expected_out = mix_expect_q.pop_front();
            if (rsp_sample_out !== expected_out) begin
               $error("sample_out mismatch: expected %0d, actual %0d",
                      expected_out, rsp_sample_out);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample_in <= value;
      do @(posedge clock); while (req_stall);
      mix_expect_q.push_back(shape_and_mix(value));
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (mix_expect_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // both registers, one transaction each; only called with the pipeline empty
   task automatic set_gains(input logic [GAIN_W-1:0] drive, input logic [GAIN_W-1:0] wet);
      csr_valid <= 1'b1;
      csr_index <= CSR_DRIVE_GAIN;
      csr_data <= drive;
      do @(posedge clock); while (!csr_ready);
      drive_gain_cfg = clamp_gain(drive);
      csr_index <= CSR_WET_MIX;
      csr_data <= wet;
      do @(posedge clock); while (!csr_ready);
      wet_mix_cfg = clamp_gain(wet);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [GAIN_W-1:0] pick_gain();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return UNITY;
         2: return GAIN_W'($urandom_range(65537, 131071));
         default: return GAIN_W'($urandom_range(0, 65536));
      endcase
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      logic signed [SAMPLE_W-1:0] v;
      case ($urandom_range(0, 9))
         0: v = 16'sh7FFF;
         1: v = -16'sh8000;
         2: begin
            v = SAMPLE_W'($urandom_range(0, 64));
            if ($urandom_range(0, 1) == 1) begin
               v = -v;
            end
         end
         default: v = SAMPLE_W'($urandom);
      endcase
      return v;
   endfunction

   task automatic test_reset_defaults();
      logic signed [SAMPLE_W-1:0] patterns [9];
      patterns = '{16'sh0000, 16'sh7FFF, -16'sh8000, 16'sh0001, -16'sh0001,
                   16'sh4000, -16'sh4000, 16'sh5555, -16'sh5556};
      foreach (patterns[i]) begin
         send_sample(patterns[i]);
      end
      drain_pipeline();
   endtask

   task automatic test_gain_extremes();
      // zero drive at full wet: the shaped term is zero, so the output is zero
      set_gains('0, UNITY);
      send_sample(16'sh7FFF);
      send_sample(-16'sh8000);
      send_sample(16'sh1234);
      drain_pipeline();
      // full-scale input at full drive hits the last table point
      set_gains(UNITY, UNITY);
      send_sample(-16'sh8000);
      send_sample(16'sh7FFF);
      send_sample(16'sh0100);
      drain_pipeline();
      set_gains(UNITY, '0);
      send_sample(-16'sh8000);
      send_sample(16'sh2AAA);
      drain_pipeline();
      // writes above unity clamp
      set_gains(GAIN_W'(131071), GAIN_W'(65537));
      send_sample(-16'sh8000);
      send_sample(16'sh6000);
      send_sample(-16'sh0003);
      drain_pipeline();
   endtask

   task automatic test_random_settings();
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         set_gains(pick_gain(), pick_gain());
         // every fourth phase runs with no gaps on either side
         idling_on <= (ph % 4 != 3);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            send_sample(pick_sample());
         end
         drain_pipeline();
      end
   endtask

   task automatic test_backpressure_fill();
      set_gains(GAIN_W'($urandom_range(0, 65536)), GAIN_W'($urandom_range(0, 65536)));
      idling_on <= 1'b0;
      hold_toggle <= ~hold_toggle;
      for (int i = 0; i < FILL_ITEMS; i++) begin
         send_sample(pick_sample());
      end
      drain_pipeline();
   endtask

   task automatic test_sender_pause();
      idling_on <= 1'b1;
      for (int i = 0; i < 20; i++) begin
         send_sample(pick_sample());
      end
      // hold the sender until every result is back, then resume
      drain_pipeline();
      for (int i = 0; i < 20; i++) begin
         send_sample(pick_sample());
      end
      drain_pipeline();
   endtask

   task automatic test_streaming_tail();
      set_gains(pick_gain(), pick_gain());
      idling_on <= 1'b0;
      for (int i = 0; i < TAIL_ITEMS; i++) begin
         send_sample(pick_sample());
      end
      drain_pipeline();
   endtask

   initial begin
      for (int k = 0; k <= TABLE_SEGMENTS; k++) begin
         tanh_lut[k] = tanh_lut_point(longint'(k));
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_gain_extremes();
      test_random_settings();
      test_backpressure_fill();
      test_sender_pause();
      test_streaming_tail();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
